@@ src/src_pkg.sv @@
// Package for the stale region coalescer: shared constants, widths and types.
// Used by every module of the block; depends on nothing.
package src_pkg;
    localparam int POS_W = 48;
    localparam int LEN_W = 32;
    localparam int BS_W = 17;
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int MAX_RUNS = 32;
    localparam logic [BS_W-1:0] BS_RESET = 17'd4096;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_EXTRACT = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV,
        S_PL_SCAN,
        S_PL_RD,
        S_PL_CMP,
        S_SH_UP_RD,
        S_SH_UP_WR,
        S_PL_WR,
        S_MG_PRV_RD,
        S_MG_PRV,
        S_MG_NXT_RD,
        S_MG_NXT,
        S_RM_RD,
        S_RM_WR,
        S_EX_RD,
        S_EX_EVAL,
        S_EX_CARVE,
        S_EX_TAIL,
        S_EX_EMIT,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] dividend;
    } div_ctl_t;
endpackage

@@ src/stale_region_coalescer.sv @@
// Stale region coalescer: sorted free-region table with merge and block carving.
// Top level; holds the sequencer and the table memory. Depends on src_pkg, src_div.
//
// Usage: requests enter on req_valid/req_ready with req_type, region_pos and
// region_len. An insert gives one response; an extract gives one response per
// carved run (up to 32) or one empty response, the final one marked by last.
// Responses leave on rsp_valid/rsp_ready from an output register. A carved run
// is held until the next run or the end of the walk is known, so last can be set.
// The sequencer waits only on the divider or to hand over a response while the
// output register is still full; a stalled receiver holds it there.
// block_size is written on cfg_valid/cfg_ready while idle; 0 acts as 1.
// An insert scans entries for its place, shifts entries up to open a slot and
// shifts them down on each merge. An extract reads each entry, runs the shared
// bit-serial divider once for each entry at least one block long and once more
// for each carved run, and places each tail. The table memory is one read port,
// one write port. One request is handled at a time; req_ready is high only while
// idle. Reset empties the table and sets block_size to 4096.
module stale_region_coalescer
    import src_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic             req_type,
    input  logic [POS_W-1:0] region_pos,
    input  logic [LEN_W-1:0] region_len,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [BS_W-1:0]  cfg_data,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output logic [1:0]       status,
    output logic             run_valid,
    output logic [POS_W-1:0] block_id,
    output logic [LEN_W-1:0] block_count,
    output logic             last
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [POS_W-1:0] mem_pos [TABLE_DEPTH];
    logic [LEN_W-1:0] mem_len [TABLE_DEPTH];

    seq_state_t state_reg, state_next, ret_reg, ret_next;
    logic [CW-1:0] cnt_reg, cnt_next, i_reg, i_next, k_reg, k_next;
    logic [5:0] n_reg, n_next;
    logic [BS_W-1:0] bs_reg, bs_next, bs_eff;
    logic typ_reg, typ_next;
    logic [POS_W-1:0] pos_reg, pos_next, p_reg, p_next;
    logic [POS_W:0] ip_reg, ip_next;
    logic [LEN_W-1:0] len_reg, len_next, l_reg, l_next, il_reg, il_next;
    logic [BS_W-1:0] front_reg, front_next;
    logic [1:0] st_reg, st_next;
    logic div_phase_reg, div_phase_next;

    logic hold_reg, hold_next;
    logic [1:0] h_st_reg, h_st_next;
    logic [POS_W-1:0] h_id_reg, h_id_next, rid_reg, rid_next;
    logic [LEN_W-1:0] h_cnt_reg, h_cnt_next, rcnt_reg, rcnt_next;

    logic rd_en;
    logic [IW-1:0] rd_addr;
    logic [POS_W-1:0] rd_pos;
    logic [LEN_W-1:0] rd_len;
    logic wr_en;
    logic [IW-1:0] wr_addr;
    logic [POS_W-1:0] wr_pos;
    logic [LEN_W-1:0] wr_len;

    logic ov_reg, ov_next;
    logic [1:0] o_st_reg, o_st_next;
    logic o_rv_reg, o_rv_next, o_last_reg, o_last_next;
    logic [POS_W-1:0] o_id_reg, o_id_next;
    logic [LEN_W-1:0] o_cnt_reg, o_cnt_next;

    div_ctl_t div_ctl;
    logic div_busy;
    logic [POS_W-1:0] div_q;
    logic [BS_W-1:0] div_r;

    logic [POS_W:0] sum_a, sum_b;
    logic [POS_W:0] diff;
    logic [POS_W:0] tpos;

    src_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .divisor   (bs_eff),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign bs_eff = (bs_reg == '0) ? BS_W'(1) : bs_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_pos[wr_addr] <= wr_pos;
            mem_len[wr_addr] <= wr_len;
        end
        if (rd_en)
        begin
            rd_pos <= mem_pos[rd_addr];
            rd_len <= mem_len[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        cnt_next = cnt_reg;
        i_next = i_reg;
        k_next = k_reg;
        n_next = n_reg;
        bs_next = bs_reg;
        typ_next = typ_reg;
        pos_next = pos_reg;
        len_next = len_reg;
        p_next = p_reg;
        l_next = l_reg;
        ip_next = ip_reg;
        il_next = il_reg;
        front_next = front_reg;
        st_next = st_reg;
        div_phase_next = div_phase_reg;
        hold_next = hold_reg;
        h_st_next = h_st_reg;
        h_id_next = h_id_reg;
        h_cnt_next = h_cnt_reg;
        rid_next = rid_reg;
        rcnt_next = rcnt_reg;
        ov_next = ov_reg;
        o_st_next = o_st_reg;
        o_rv_next = o_rv_reg;
        o_id_next = o_id_reg;
        o_cnt_next = o_cnt_reg;
        o_last_next = o_last_reg;
        rd_en = 1'b0;
        rd_addr = '0;
        wr_en = 1'b0;
        wr_addr = '0;
        wr_pos = '0;
        wr_len = '0;
        div_ctl.start = 1'b0;
        div_ctl.dividend = '0;
        req_ready = 1'b0;
        cfg_ready = (state_reg == S_IDLE);
        sum_a = '0;
        sum_b = '0;
        diff = '0;
        tpos = '0;

        if (ov_reg && rsp_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (cfg_valid)
                begin
                    bs_next = cfg_data;
                end
                if (req_valid)
                begin
                    typ_next = req_type;
                    pos_next = region_pos;
                    len_next = region_len;
                    st_next = ST_OK;
                    i_next = '0;
                    n_next = '0;
                    hold_next = 1'b0;
                    if (req_type == REQ_INSERT)
                    begin
                        ret_next = S_MG_PRV_RD;
                        state_next = S_PL_SCAN;
                    end
                    else
                    begin
                        state_next = S_EX_RD;
                    end
                end
            end
            // place pos_reg/len_reg: lower-bound scan
            S_PL_SCAN:
            begin
                if (i_reg < cnt_reg)
                begin
                    rd_en = 1'b1;
                    rd_addr = IW'(i_reg);
                    state_next = S_PL_RD;
                end
                else
                begin
                    state_next = S_PL_CMP;
                end
            end
            S_PL_RD:
            begin
                if (rd_pos < pos_reg)
                begin
                    i_next = i_reg + CW'(1);
                    state_next = S_PL_SCAN;
                end
                else
                begin
                    state_next = S_PL_CMP;
                end
            end
            S_PL_CMP:
            begin
                if (i_reg < cnt_reg && rd_pos == pos_reg)
                begin
                    if (rd_len < len_reg)
                    begin
                        wr_en = 1'b1;
                        wr_addr = IW'(i_reg);
                        wr_pos = pos_reg;
                        wr_len = len_reg;
                    end
                    state_next = ret_reg;
                end
                else if (cnt_reg >= CW'(TABLE_DEPTH))
                begin
                    i_next = CW'(TABLE_DEPTH);
                    st_next = ST_FULL;
                    state_next = ret_reg;
                end
                else
                begin
                    k_next = cnt_reg;
                    state_next = S_SH_UP_RD;
                end
            end
            S_SH_UP_RD:
            begin
                if (k_reg > i_reg)
                begin
                    rd_en = 1'b1;
                    rd_addr = IW'(k_reg - CW'(1));
                    state_next = S_SH_UP_WR;
                end
                else
                begin
                    state_next = S_PL_WR;
                end
            end
            S_SH_UP_WR:
            begin
                wr_en = 1'b1;
                wr_addr = IW'(k_reg);
                wr_pos = rd_pos;
                wr_len = rd_len;
                k_next = k_reg - CW'(1);
                state_next = S_SH_UP_RD;
            end
            S_PL_WR:
            begin
                wr_en = 1'b1;
                wr_addr = IW'(i_reg);
                wr_pos = pos_reg;
                wr_len = len_reg;
                cnt_next = cnt_reg + CW'(1);
                state_next = ret_reg;
            end
            // insert merge with the previous and next entries
            S_MG_PRV_RD:
            begin
                if (st_reg == ST_FULL)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = IW'(i_reg);
                    state_next = S_MG_PRV;
                    div_phase_next = 1'b0;
                end
            end
            S_MG_PRV:
            begin
                if (!div_phase_reg)
                begin
                    p_next = rd_pos;
                    l_next = rd_len;
                    if (i_reg != '0)
                    begin
                        rd_en = 1'b1;
                        rd_addr = IW'(i_reg - CW'(1));
                        div_phase_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_MG_NXT_RD;
                    end
                end
                else
                begin
                    sum_a = {1'b0, rd_pos} + {{(POS_W-LEN_W+1){1'b0}}, rd_len};
                    sum_b = {1'b0, p_reg} + {{(POS_W-LEN_W+1){1'b0}}, l_reg};
                    if (sum_a >= {1'b0, p_reg})
                    begin
                        if (sum_b > sum_a)
                        begin
                            diff = sum_b - {1'b0, rd_pos};
                            wr_en = 1'b1;
                            wr_addr = IW'(i_reg - CW'(1));
                            wr_pos = rd_pos;
                            if (diff[POS_W:LEN_W] != '0)
                            begin
                                wr_len = '1;
                                st_next = ST_SAT;
                            end
                            else
                            begin
                                wr_len = diff[LEN_W-1:0];
                            end
                        end
                        k_next = i_reg;
                        i_next = i_reg - CW'(1);
                        ret_next = S_MG_NXT_RD;
                        state_next = S_RM_RD;
                    end
                    else
                    begin
                        state_next = S_MG_NXT_RD;
                    end
                end
            end
            S_MG_NXT_RD:
            begin
                if (i_reg + CW'(1) < cnt_reg)
                begin
                    rd_en = 1'b1;
                    rd_addr = IW'(i_reg);
                    div_phase_next = 1'b0;
                    state_next = S_MG_NXT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_MG_NXT:
            begin
                if (!div_phase_reg)
                begin
                    p_next = rd_pos;
                    l_next = rd_len;
                    rd_en = 1'b1;
                    rd_addr = IW'(i_reg + CW'(1));
                    div_phase_next = 1'b1;
                end
                else
                begin
                    sum_a = {1'b0, p_reg} + {{(POS_W-LEN_W+1){1'b0}}, l_reg};
                    sum_b = {1'b0, rd_pos} + {{(POS_W-LEN_W+1){1'b0}}, rd_len};
                    if (sum_a >= {1'b0, rd_pos})
                    begin
                        if (sum_b > sum_a)
                        begin
                            diff = sum_b - {1'b0, p_reg};
                            wr_en = 1'b1;
                            wr_addr = IW'(i_reg);
                            wr_pos = p_reg;
                            if (diff[POS_W:LEN_W] != '0)
                            begin
                                wr_len = '1;
                                st_next = ST_SAT;
                            end
                            else
                            begin
                                wr_len = diff[LEN_W-1:0];
                            end
                        end
                        k_next = i_reg + CW'(1);
                        ret_next = S_OUT;
                        state_next = S_RM_RD;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            // remove entry k_reg: shift down
            S_RM_RD:
            begin
                if (k_reg + CW'(1) < cnt_reg)
                begin
                    rd_en = 1'b1;
                    rd_addr = IW'(k_reg + CW'(1));
                    state_next = S_RM_WR;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                    state_next = ret_reg;
                end
            end
            S_RM_WR:
            begin
                wr_en = 1'b1;
                wr_addr = IW'(k_reg);
                wr_pos = rd_pos;
                wr_len = rd_len;
                k_next = k_reg + CW'(1);
                state_next = S_RM_RD;
            end
            // extract walk
            S_EX_RD:
            begin
                if (i_reg < cnt_reg && n_reg < 6'(MAX_RUNS))
                begin
                    rd_en = 1'b1;
                    rd_addr = IW'(i_reg);
                    div_phase_next = 1'b0;
                    state_next = S_EX_EVAL;
                end
                else if (n_reg == '0)
                begin
                    st_next = ST_OK;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_EX_EVAL:
            begin
                p_next = rd_pos;
                l_next = rd_len;
                if ({{(LEN_W-BS_W){1'b0}}, bs_eff} > rd_len)
                begin
                    i_next = i_reg + CW'(1);
                    state_next = S_EX_RD;
                end
                else
                begin
                    div_ctl.start = 1'b1;
                    div_ctl.dividend = rd_pos;
                    state_next = S_DIV;
                    ret_next = S_EX_CARVE;
                end
            end
            S_DIV:
            begin
                if (!div_busy && !div_ctl.start)
                begin
                    state_next = ret_reg;
                end
            end
            S_EX_CARVE:
            begin
                if (!div_phase_reg)
                begin
                    front_next = (div_r == '0) ? '0 : BS_W'(bs_eff - div_r);
                    diff = {{(POS_W-LEN_W+1){1'b0}}, l_reg}
                         - {{(POS_W-BS_W+1){1'b0}},
                            ((div_r == '0) ? BS_W'(0) : BS_W'(bs_eff - div_r))};
                    if (diff[POS_W] || diff[LEN_W-1:0] < {{(LEN_W-BS_W){1'b0}}, bs_eff})
                    begin
                        i_next = i_reg + CW'(1);
                        state_next = S_EX_RD;
                    end
                    else
                    begin
                        il_next = diff[LEN_W-1:0];
                        ip_next = {1'b0, p_reg} + {{(POS_W-BS_W+1){1'b0}},
                            ((div_r == '0) ? BS_W'(0) : BS_W'(bs_eff - div_r))};
                        rid_next = (div_r == '0) ? div_q : div_q + POS_W'(1);
                        div_ctl.start = 1'b1;
                        div_ctl.dividend = {{(POS_W-LEN_W){1'b0}}, diff[LEN_W-1:0]};
                        div_phase_next = 1'b1;
                        ret_next = S_EX_CARVE;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    rcnt_next = div_q[LEN_W-1:0];
                    st_next = ST_OK;
                    if (front_reg != '0)
                    begin
                        wr_en = 1'b1;
                        wr_addr = IW'(i_reg);
                        wr_pos = p_reg;
                        wr_len = {{(LEN_W-BS_W){1'b0}}, front_reg};
                        i_next = i_reg + CW'(1);
                        state_next = S_EX_TAIL;
                    end
                    else
                    begin
                        k_next = i_reg;
                        ret_next = S_EX_TAIL;
                        state_next = S_RM_RD;
                    end
                end
            end
            S_EX_TAIL:
            begin
                tpos = ip_reg + {{(POS_W-LEN_W+1){1'b0}}, il_reg}
                     - {{(POS_W-BS_W+1){1'b0}}, div_r};
                if (div_r != '0 && !tpos[POS_W])
                begin
                    pos_next = tpos[POS_W-1:0];
                    len_next = {{(LEN_W-BS_W){1'b0}}, div_r};
                    k_next = i_reg;
                    i_next = '0;
                    ret_next = S_EX_EMIT;
                    state_next = S_PL_SCAN;
                end
                else
                begin
                    st_next = ST_OK;
                    state_next = S_EX_EMIT;
                    i_next = i_reg;
                    k_next = CW'(TABLE_DEPTH + 1);
                end
            end
            // hand the held run to the output, hold the new one
            S_EX_EMIT:
            begin
                if (!hold_reg || !ov_reg || rsp_ready)
                begin
                    if (hold_reg)
                    begin
                        ov_next = 1'b1;
                        o_st_next = h_st_reg;
                        o_rv_next = 1'b1;
                        o_id_next = h_id_reg;
                        o_cnt_next = h_cnt_reg;
                        o_last_next = 1'b0;
                    end
                    hold_next = 1'b1;
                    h_id_next = rid_reg;
                    h_cnt_next = rcnt_reg;
                    n_next = n_reg + 6'd1;
                    if (k_reg == CW'(TABLE_DEPTH + 1))
                    begin
                        h_st_next = ST_OK;
                    end
                    else if (st_reg == ST_FULL)
                    begin
                        h_st_next = ST_FULL;
                        i_next = k_reg;
                    end
                    else
                    begin
                        h_st_next = ST_OK;
                        i_next = i_reg + CW'(1);
                    end
                    st_next = ST_OK;
                    state_next = S_EX_RD;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || rsp_ready)
                begin
                    ov_next = 1'b1;
                    o_last_next = 1'b1;
                    hold_next = 1'b0;
                    state_next = S_IDLE;
                    if (hold_reg)
                    begin
                        o_st_next = h_st_reg;
                        o_rv_next = 1'b1;
                        o_id_next = h_id_reg;
                        o_cnt_next = h_cnt_reg;
                    end
                    else
                    begin
                        o_st_next = (typ_reg == REQ_INSERT) ? st_reg : ST_OK;
                        o_rv_next = 1'b0;
                        o_id_next = '0;
                        o_cnt_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg <= S_IDLE;
            cnt_reg <= '0;
            bs_reg <= BS_RESET;
            ov_reg <= 1'b0;
            div_phase_reg <= 1'b0;
            hold_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            cnt_reg <= cnt_next;
            bs_reg <= bs_next;
            ov_reg <= ov_next;
            div_phase_reg <= div_phase_next;
            hold_reg <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        k_reg <= k_next;
        n_reg <= n_next;
        typ_reg <= typ_next;
        pos_reg <= pos_next;
        len_reg <= len_next;
        p_reg <= p_next;
        l_reg <= l_next;
        ip_reg <= ip_next;
        il_reg <= il_next;
        front_reg <= front_next;
        st_reg <= st_next;
        h_st_reg <= h_st_next;
        h_id_reg <= h_id_next;
        h_cnt_reg <= h_cnt_next;
        rid_reg <= rid_next;
        rcnt_reg <= rcnt_next;
        o_st_reg <= o_st_next;
        o_rv_reg <= o_rv_next;
        o_id_reg <= o_id_next;
        o_cnt_reg <= o_cnt_next;
        o_last_reg <= o_last_next;
    end

    assign rsp_valid = ov_reg;
    assign status = o_st_reg;
    assign run_valid = o_rv_reg;
    assign block_id = o_id_reg;
    assign block_count = o_cnt_reg;
    assign last = o_last_reg;
endmodule

@@ src/src_div.sv @@
// Shared restoring divider: 48-bit dividend by a 17-bit divisor, one bit a cycle.
// Depends on src_pkg.
module src_div
    import src_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctl_t         ctl,
    input  logic [BS_W-1:0]  divisor,
    output logic             busy,
    output logic [POS_W-1:0] quotient,
    output logic [BS_W-1:0]  remainder
);
    logic [POS_W-1:0] quot_reg, quot_next;
    logic [BS_W-1:0]  rem_reg, rem_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [BS_W:0]    trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg, quot_reg[POS_W-1]};
        if (ctl.start)
        begin
            quot_next = ctl.dividend;
            rem_next = '0;
            cnt_next = 6'(POS_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = BS_W'(trial - {1'b0, divisor});
                quot_next = {quot_reg[POS_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[BS_W-1:0];
                quot_next = {quot_reg[POS_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            busy_next = (cnt_reg != 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign quotient = quot_reg;
    assign remainder = rem_reg;
endmodule

@@ test/stale_region_coalescer_tb.sv @@
// Testbench for stale_region_coalescer: directed table, fill and block-size cases,
// then random requests, each response checked against a built-in model of the free-region table.
// Depends on src_pkg and the stale_region_coalescer RTL.
module stale_region_coalescer_tb;
    import src_pkg::*;

    localparam int DEPTH = 32;
    localparam int WATCH_LIMIT = 20000;

    typedef struct {
        logic [1:0]       st;
        logic             rv;
        logic [POS_W-1:0] bid;
        logic [LEN_W-1:0] cnt;
        logic             lst;
    } rsp_t;

    typedef struct {
        logic             typ;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        bit               has_exp;
        logic [1:0]       exp_st;
    } row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic req_valid = 0;
    logic req_ready;
    logic req_type = 0;
    logic [POS_W-1:0] region_pos = '0;
    logic [LEN_W-1:0] region_len = '0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [BS_W-1:0] cfg_data = '0;
    logic rsp_valid;
    logic rsp_ready = 0;
    logic [1:0] status;
    logic run_valid;
    logic [POS_W-1:0] block_id;
    logic [LEN_W-1:0] block_count;
    logic last;

    always #4 clk = ~clk;

    stale_region_coalescer dut (.*);

    logic [63:0] tbl_pos [DEPTH];
    logic [63:0] tbl_len [DEPTH];
    int unsigned tbl_n;
    logic [63:0] cur_bs;

    rsp_t pending_rsp[$];
    int errors = 0;
    int n_req = 0, n_rsp = 0, n_runs = 0, n_full = 0, n_sat = 0;
    int idle_pct = 36;
    int quiet = 0;
    bit hold_rsp_idle = 0;
    logic [1:0] seen_st = '0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic int unsigned find_slot(input logic [63:0] p);
        int unsigned i = 0;
        while (i < tbl_n && tbl_pos[i] < p) i++;
        return i;
    endfunction

    function automatic void open_slot(input int unsigned i, input logic [63:0] p,
                                      input logic [63:0] l);
        for (int unsigned k = tbl_n; k > i; k--)
        begin
            tbl_pos[k] = tbl_pos[k-1];
            tbl_len[k] = tbl_len[k-1];
        end
        tbl_pos[i] = p;
        tbl_len[i] = l;
        tbl_n++;
    endfunction

    function automatic void close_slot(input int unsigned i);
        for (int unsigned k = i; k + 1 < tbl_n; k++)
        begin
            tbl_pos[k] = tbl_pos[k+1];
            tbl_len[k] = tbl_len[k+1];
        end
        tbl_n--;
    endfunction

    function automatic int unsigned place_region(input logic [63:0] p, input logic [63:0] l);
        int unsigned i;
        i = find_slot(p);
        if (i < tbl_n && tbl_pos[i] == p)
        begin
            if (tbl_len[i] < l) tbl_len[i] = l;
            return i;
        end
        if (tbl_n >= DEPTH) return DEPTH;
        open_slot(i, p, l);
        return i;
    endfunction

    function automatic logic [1:0] merge_insert(input logic [63:0] p, input logic [63:0] l);
        logic [1:0] st = ST_OK;
        int unsigned i;
        logic [63:0] a_end, b_end, nl;
        i = place_region(p, l);
        if (i >= DEPTH) return ST_FULL;
        if (i > 0)
        begin
            a_end = tbl_pos[i-1] + tbl_len[i-1];
            b_end = tbl_pos[i] + tbl_len[i];
            if (a_end >= tbl_pos[i])
            begin
                if (b_end > a_end)
                begin
                    nl = b_end - tbl_pos[i-1];
                    if (nl > 64'hFFFF_FFFF) begin nl = 64'hFFFF_FFFF; st = ST_SAT; end
                    tbl_len[i-1] = nl;
                end
                close_slot(i);
                i--;
            end
        end
        if (i + 1 < tbl_n)
        begin
            a_end = tbl_pos[i] + tbl_len[i];
            b_end = tbl_pos[i+1] + tbl_len[i+1];
            if (a_end >= tbl_pos[i+1])
            begin
                if (b_end > a_end)
                begin
                    nl = b_end - tbl_pos[i];
                    if (nl > 64'hFFFF_FFFF) begin nl = 64'hFFFF_FFFF; st = ST_SAT; end
                    tbl_len[i] = nl;
                end
                close_slot(i + 1);
            end
        end
        return st;
    endfunction

    function automatic void predict_region_request(input logic typ, input logic [63:0] p,
                                                   input logic [63:0] l);
        rsp_t r;
        rsp_t runs[$];
        logic [63:0] bs, rp, rl, front, ip, il, tail, tpos;
        int unsigned i = 0, j;
        bs = (cur_bs == 0) ? 64'd1 : cur_bs;
        if (typ == REQ_INSERT)
        begin
            r = '{merge_insert(p, l), 1'b0, '0, '0, 1'b1};
            pending_rsp.push_back(r);
            return;
        end
        while (i < tbl_n && runs.size() < MAX_RUNS)
        begin
            rp = tbl_pos[i];
            rl = tbl_len[i];
            if (rl < bs) begin i++; continue; end
            front = (rp % bs != 0) ? bs - rp % bs : 0;
            ip = rp + front;
            il = rl - front;
            if (il < bs) begin i++; continue; end
            r = '{ST_OK, 1'b1, POS_W'(ip / bs), LEN_W'(il / bs), 1'b0};
            tail = il % bs;
            if (front != 0)
            begin
                tbl_len[i] = front;
                i++;
            end
            else
                close_slot(i);
            if (tail != 0)
            begin
                tpos = ip + (il - tail);
                if (tpos <= 64'hFFFF_FFFF_FFFF)
                begin
                    j = place_region(tpos, tail);
                    if (j >= DEPTH) r.st = ST_FULL;
                    else i = j + 1;
                end
            end
            runs.push_back(r);
        end
        if (runs.size() == 0)
            runs.push_back('{ST_OK, 1'b0, '0, '0, 1'b1});
        runs[runs.size()-1].lst = 1'b1;
        foreach (runs[k]) pending_rsp.push_back(runs[k]);
    endfunction

    always @(posedge clk)
    begin
        if (req_valid && req_ready) quiet <= 0;
        else if (rsp_valid && rsp_ready) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCH_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rsp_t w;
        if (rsp_valid && rsp_ready)
        begin
            n_rsp++;
            seen_st = status;
            if (pending_rsp.size() == 0)
                report("unexpected response", {status, run_valid}, 0);
            else
            begin
                w = pending_rsp.pop_front();
                if (status != w.st) report("status", status, w.st);
                if (run_valid != w.rv) report("run_valid", run_valid, w.rv);
                if (block_id != w.bid) report("block_id", block_id, w.bid);
                if (block_count != w.cnt) report("block_count", block_count, w.cnt);
                if (last != w.lst) report("last", last, w.lst);
                if (w.rv) n_runs++;
                if (w.st == ST_FULL) n_full++;
                if (w.st == ST_SAT) n_sat++;
            end
        end
        if (hold_rsp_idle) rsp_ready <= 1'b1;
        else rsp_ready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic write_block_size(input logic [BS_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_bs = v;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic send_region_request(input logic typ, input logic [POS_W-1:0] p,
                                       input logic [LEN_W-1:0] l);
        if ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        req_valid <= 1'b1;
        req_type <= typ;
        region_pos <= p;
        region_len <= l;
        do @(posedge clk); while (!req_ready);
        predict_region_request(typ, p, l);
        n_req++;
    endtask

    function automatic logic [LEN_W-1:0] rand_len();
        case ($urandom_range(5))
            0: return $urandom_range(200);
            1: return $urandom;
            2: return LEN_W'(cur_bs * $urandom_range(1, 6) + $urandom_range(3));
            default: return $urandom_range(20000);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] rand_pos(input int dense);
        if (dense != 0) return $urandom_range(300000);
        case ($urandom_range(3))
            0: return POS_W'({$urandom, $urandom});
            1: return 48'hFFFF_FFFF_FFFF - $urandom_range(70000);
            default: return $urandom_range(2000000);
        endcase
    endfunction

    row_t directed[] = '{
        '{REQ_EXTRACT, 48'd0, 32'd0, 1, ST_OK},
        '{REQ_INSERT, 48'd0, 32'd0, 1, ST_OK},
        '{REQ_INSERT, 48'd4096, 32'd8192, 1, ST_OK},
        '{REQ_INSERT, 48'd4096, 32'd100, 1, ST_OK},
        '{REQ_INSERT, 48'd12288, 32'd5000, 0, ST_OK},
        '{REQ_INSERT, 48'd1000, 32'd3096, 0, ST_OK},
        '{REQ_EXTRACT, 48'd0, 32'd0, 0, ST_OK},
        '{REQ_INSERT, 48'h1000_0000, 32'hFFFF_FFFF, 1, ST_OK},
        '{REQ_INSERT, 48'h1000_0010, 32'hFFFF_FFFF, 1, ST_SAT},
        '{REQ_INSERT, 48'hFFFF_FFFF_F000, 32'hFFFF_FFFF, 1, ST_OK},
        '{REQ_INSERT, 48'hFFFF_FFFF_FFFF, 32'h1, 0, ST_OK},
        '{REQ_EXTRACT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0, ST_OK},
        '{REQ_INSERT, 48'd77, 32'd10, 0, ST_OK},
        '{REQ_EXTRACT, 48'd0, 32'd0, 0, ST_OK}
    };

    initial
    begin
        int k;
        logic typ;
        cur_bs = BS_RESET;
        tbl_n = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[r])
        begin
            send_region_request(directed[r].typ, directed[r].pos, directed[r].len);
            if (directed[r].has_exp)
            begin
                req_valid <= 1'b0;
                do @(posedge clk); while (pending_rsp.size() != 0);
                if (seen_st != directed[r].exp_st)
                    report("directed status", seen_st, directed[r].exp_st);
                if (tbl_n > DEPTH) report("table model", tbl_n, DEPTH);
            end
        end
        drain();

        // fill the table with separated regions, then overflow it
        write_block_size(17'd16);
        for (k = 0; k < DEPTH + 3; k++)
            send_region_request(REQ_INSERT, 48'd1000 * k + 5, 32'd100);
        send_region_request(REQ_EXTRACT, '0, '0);
        drain();
        write_block_size(17'd0);
        send_region_request(REQ_INSERT, 48'd3, 32'd5);
        send_region_request(REQ_EXTRACT, '0, '0);
        drain();
        write_block_size(17'h10000);
        send_region_request(REQ_INSERT, 48'h1_0000 - 1, 32'h3_0002);
        send_region_request(REQ_EXTRACT, '0, '0);
        drain();

        for (k = 0; k < 450; k++)
        begin
            if (k % 90 == 0)
            begin
                drain();
                case ((k / 90) % 5)
                    0: write_block_size(17'd1);
                    1: write_block_size(17'h10000);
                    2: write_block_size(BS_RESET);
                    3: write_block_size(BS_W'($urandom_range(1, 512)));
                    default: write_block_size(BS_W'($urandom_range(0, 17'h1FFFF)));
                endcase
            end
            idle_pct = (k >= 180 && k < 260) ? 0 : 36;
            hold_rsp_idle = (k >= 180 && k < 260);
            if (k == 300)
            begin
                req_valid <= 1'b0;
                do @(posedge clk); while (pending_rsp.size() != 0);
            end
            typ = ($urandom_range(99) < 20) ? REQ_EXTRACT : REQ_INSERT;
            send_region_request(typ, rand_pos($urandom_range(99) < 80), rand_len());
        end
        hold_rsp_idle = 0;
        idle_pct = 36;
        send_region_request(REQ_EXTRACT, '0, '0);
        drain();

        $display("ran %0d requests, %0d responses, %0d carved runs", n_req, n_rsp, n_runs);
        $display("table-full responses %0d, saturated responses %0d", n_full, n_sat);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
